@@ rtl/ntat_pkg.sv @@
package ntat_pkg;

  localparam int unsigned MAX_DIVISIONS = 100;

  localparam int unsigned IN_W    = 48;  // window timestamps
  localparam int unsigned POS_W   = 49;  // ordered bounds, one hour headroom
  localparam int unsigned OUT_W   = 50;  // snapped bounds
  localparam int unsigned CNT_W   = 10;  // division count
  localparam int unsigned RUNG_W  = 32;  // ladder steps
  localparam int unsigned MUL_W   = 50;  // shared multiplier operands
  localparam int unsigned RUNGS   = 7;

  localparam logic [RUNG_W-1:0] HOUR_MS = 32'd3600000;
  localparam logic [RUNG_W-1:0] DAY_MS  = 32'd86400000;
  localparam logic [OUT_W:0] FMT_CLOCK_MAX = 51'd172800000;    // 2 days
  localparam logic [OUT_W:0] FMT_DAY_MAX   = 51'd10368000000;  // 120 days

  localparam logic [1:0] FMT_CLOCK = 2'd0;
  localparam logic [1:0] FMT_DAY   = 2'd1;
  localparam logic [1:0] FMT_YEAR  = 2'd2;

  function automatic logic [RUNG_W-1:0] rung(input logic [2:0] idx);
    logic [RUNG_W-1:0] r;
    unique case (idx)
      3'd0:    r = HOUR_MS;
      3'd1:    r = 32'd10800000;
      3'd2:    r = 32'd21600000;
      3'd3:    r = 32'd43200000;
      3'd4:    r = DAY_MS;
      3'd5:    r = 32'd604800000;
      3'd6:    r = 32'd2592000000;
      default: r = HOUR_MS;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ntat_mul.sv @@
module ntat_mul #(
  parameter int unsigned W = ntat_pkg::MUL_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int unsigned CW = $clog2(W);

  logic [2*W-1:0] a_sh;
  logic [W-1:0]   b_sh;
  logic [CW-1:0]  cnt;
  logic           run;

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        prod <= '0;
        a_sh <= {{W{1'b0}}, a};
        b_sh <= b;
        cnt  <= '0;
      end else if (run) begin
        if (b_sh[0]) prod <= prod + a_sh;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/ntat_div.sv @@
module ntat_div #(
  parameter int unsigned N = ntat_pkg::POS_W,
  parameter int unsigned D = ntat_pkg::RUNG_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quo,
  output logic         rem_nz
);

  localparam int unsigned CW = $clog2(N);

  logic [D-1:0]  rem;
  logic [N-1:0]  n_sh;
  logic [D-1:0]  dv;
  logic [CW-1:0] cnt;
  logic          run;
  logic [D:0]    r2;
  logic          fits;

  assign r2     = {rem, n_sh[N-1]};
  assign fits   = r2 >= {1'b0, dv};
  assign rem_nz = |rem;

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        rem  <= '0;
        n_sh <= dividend;
        dv   <= divisor;
        cnt  <= '0;
      end else if (run) begin
        rem  <= fits ? D'(r2 - {1'b0, dv}) : r2[D-1:0];
        n_sh <= n_sh << 1;
        quo  <= {quo[N-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(N - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/nice_time_axis_ticks_unit.sv @@
// channel  dir  handshake              payload
// cfg      in   cfg_valid/cfg_ready    cfg_data (target_ticks)
// in       in   in_valid/in_ready      window_start_ms, window_end_ms
// out      out  out_valid/out_ready    division_count, axis_start_ms, axis_end_ms, label_format
//
// One window runs from input beat to result through six ratio compares of two
// serial multiplies each, two serial divisions, the step doublings that bring
// the count within MAX_DIVISIONS, then two more serial multiplies for the
// snapped bounds.
// in_ready is high only while the sequencer is idle; cfg_ready is always high.
// Reset (rst, synchronous) sets target_ticks to 6 and empties the output.
// A finished result waits in the output register until out_ready.
module nice_time_axis_ticks_unit #(
  parameter int unsigned MAX_DIVISIONS = ntat_pkg::MAX_DIVISIONS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [7:0]                          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ntat_pkg::IN_W-1:0]    window_start_ms,
  input  logic signed [ntat_pkg::IN_W-1:0]    window_end_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ntat_pkg::CNT_W-1:0]          division_count,
  output logic signed [ntat_pkg::OUT_W-1:0]   axis_start_ms,
  output logic signed [ntat_pkg::OUT_W-1:0]   axis_end_ms,
  output logic [1:0]                          label_format
);

  localparam int unsigned PW = ntat_pkg::POS_W;
  localparam int unsigned OW = ntat_pkg::OUT_W;
  localparam int unsigned MW = ntat_pkg::MUL_W;
  localparam int unsigned RW = ntat_pkg::RUNG_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CMP  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M1W  = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M2W  = 4'd5;
  localparam logic [3:0] S_DL   = 4'd6;
  localparam logic [3:0] S_DLW  = 4'd7;
  localparam logic [3:0] S_DH   = 4'd8;
  localparam logic [3:0] S_DHW  = 4'd9;
  localparam logic [3:0] S_DBL  = 4'd10;
  localparam logic [3:0] S_ML   = 4'd11;
  localparam logic [3:0] S_MLW  = 4'd12;
  localparam logic [3:0] S_MH   = 4'd13;
  localparam logic [3:0] S_MHW  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0]           state;
  logic [7:0]           target_ticks;
  logic [7:0]           div_r;
  logic signed [PW-1:0] lo;
  logic signed [PW-1:0] hi;
  logic [PW-2:0]        span;
  logic [2:0]           idx;
  logic [2:0]           best_idx;
  logic [PW-2:0]        num;
  logic [PW-2:0]        den;
  logic [PW-2:0]        best_num;
  logic [PW-2:0]        best_den;
  logic [2*MW-1:0]      p1;
  logic signed [OW-1:0] ql;
  logic signed [OW-1:0] qh;
  logic [OW-1:0]        step;
  logic [ntat_pkg::CNT_W-1:0] count;
  logic signed [OW-1:0] smin;
  logic signed [OW-1:0] smax;

  // accept-time ordering
  logic signed [PW-1:0] a_s, a_e, a_lo, a_hi, a_dif;
  logic [7:0]           a_ticks;

  assign a_s     = PW'(window_start_ms);
  assign a_e     = PW'(window_end_ms);
  assign a_lo    = (a_e < a_s) ? a_e : a_s;
  assign a_hi    = (a_e < a_s) ? a_s : a_e;
  assign a_dif   = a_hi - a_lo;
  assign a_ticks = (target_ticks < 8'd2) ? 8'd2 : target_ticks;

  // ratio of rung to span/div, as num/den with num >= den
  logic [RW+7:0] rd;
  logic [PW-2:0] rd_w;
  assign rd   = RW'(ntat_pkg::rung(idx)) * div_r;
  assign rd_w = (PW-1)'(rd);

  // shared units
  logic            mul_start, mul_done;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  logic            div_start, div_done, div_nz;
  logic [PW-1:0]   div_n, div_q;
  logic [RW-1:0]   div_d;

  logic [OW-1:0] ql_mag, qh_mag;
  assign ql_mag = ql[OW-1] ? OW'(-ql) : OW'(ql);
  assign qh_mag = qh[OW-1] ? OW'(-qh) : OW'(qh);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = MW'(num);
    mul_b     = MW'(best_den);
    unique case (state)
      S_M1: mul_start = 1'b1;
      S_M2: begin
        mul_start = 1'b1;
        mul_a     = MW'(best_num);
        mul_b     = MW'(den);
      end
      S_ML: begin
        mul_start = 1'b1;
        mul_a     = ql_mag;
        mul_b     = step;
      end
      S_MH: begin
        mul_start = 1'b1;
        mul_a     = qh_mag;
        mul_b     = step;
      end
      default: ;
    endcase
  end

  assign div_start = (state == S_DL) || (state == S_DH);
  assign div_n     = (state == S_DL) ? (lo[PW-1] ? PW'(-lo) : PW'(lo))
                                     : (hi[PW-1] ? PW'(-hi) : PW'(hi));
  assign div_d     = ntat_pkg::rung(best_idx);

  ntat_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  ntat_div #(.N(PW), .D(RW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_q),
    .rem_nz   (div_nz)
  );

  logic signed [OW-1:0] q_ext, q_cnt, q_lo_next, q_hi_next;
  assign q_ext     = OW'(div_q);
  assign q_lo_next = lo[PW-1] ? -(q_ext + OW'(div_nz)) : q_ext;
  assign q_hi_next = hi[PW-1] ? -q_ext : (q_ext + OW'(div_nz));
  assign q_cnt     = qh - ql;

  logic signed [OW-1:0] bound;
  assign bound = (state == S_MLW ? ql[OW-1] : qh[OW-1]) ? -OW'(mul_p) : OW'(mul_p);

  logic [OW:0] sspan;
  assign sspan = (OW+1)'(smax) - (OW+1)'(smin);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      target_ticks <= 8'd6;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) target_ticks <= cfg_data;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          lo    <= a_lo;
          div_r <= a_ticks - 8'd1;
          idx   <= '0;
          if (a_dif == '0) begin
            hi   <= a_lo + PW'(ntat_pkg::HOUR_MS);
            span <= (PW-1)'(ntat_pkg::HOUR_MS);
          end else begin
            hi   <= a_hi;
            span <= (PW-1)'(a_dif);
          end
          state <= S_CMP;
        end
        S_CMP: begin
          num <= (rd_w >= span) ? rd_w : span;
          den <= (rd_w >= span) ? span : rd_w;
          if (idx == '0) begin
            best_num <= (rd_w >= span) ? rd_w : span;
            best_den <= (rd_w >= span) ? span : rd_w;
            best_idx <= '0;
            idx      <= 3'd1;
          end else begin
            state <= S_M1;
          end
        end
        S_M1:  state <= S_M1W;
        S_M1W: if (mul_done) begin
          p1    <= mul_p;
          state <= S_M2;
        end
        S_M2:  state <= S_M2W;
        S_M2W: if (mul_done) begin
          // strict less: on a tie the smaller step stays
          if (p1 < mul_p) begin
            best_num <= num;
            best_den <= den;
            best_idx <= idx;
          end
          if (idx == 3'(ntat_pkg::RUNGS - 1)) begin
            state <= S_DL;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_CMP;
          end
        end
        S_DL: begin
          step  <= OW'(ntat_pkg::rung(best_idx));
          state <= S_DLW;
        end
        S_DLW: if (div_done) begin
          ql    <= q_lo_next;
          state <= S_DH;
        end
        S_DH:  state <= S_DHW;
        S_DHW: if (div_done) begin
          qh    <= q_hi_next;
          state <= S_DBL;
        end
        S_DBL: begin
          // doubling the step: floor and ceil quotients just halve
          if (q_cnt > OW'(MAX_DIVISIONS)) begin
            ql   <= ql >>> 1;
            qh   <= (qh + OW'(1)) >>> 1;
            step <= step << 1;
          end else begin
            count <= (q_cnt < OW'(1)) ? ntat_pkg::CNT_W'(1) : ntat_pkg::CNT_W'(q_cnt);
            state <= S_ML;
          end
        end
        S_ML:  state <= S_MLW;
        S_MLW: if (mul_done) begin
          smin  <= bound;
          state <= S_MH;
        end
        S_MH:  state <= S_MHW;
        S_MHW: if (mul_done) begin
          smax  <= bound;
          state <= S_FIN;
        end
        S_FIN: if (!out_valid || out_ready) begin
          out_valid      <= 1'b1;
          division_count <= count;
          axis_start_ms  <= smin;
          axis_end_ms    <= smax;
          if (sspan <= ntat_pkg::FMT_CLOCK_MAX)    label_format <= ntat_pkg::FMT_CLOCK;
          else if (sspan <= ntat_pkg::FMT_DAY_MAX) label_format <= ntat_pkg::FMT_DAY;
          else                                     label_format <= ntat_pkg::FMT_YEAR;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_M1W || state == S_M2W || state == S_MLW || state == S_MHW))
    else $error("multiplier done outside a wait state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DLW || state == S_DHW))
    else $error("divider done outside a wait state");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> division_count >= 10'd1 && division_count <= 10'(MAX_DIVISIONS))
    else $error("division count out of range");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> axis_end_ms > axis_start_ms)
    else $error("snapped bounds out of order");

endmodule
